### src/page_frame_allocator_defines.svh
// Assertion macros for the page frame allocator RTL.
`ifndef PAGE_FRAME_ALLOCATOR_DEFINES_SVH
`define PAGE_FRAME_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define PFA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfa assertion failed");

// Next-cycle implication.
`define PFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfa assertion failed");

`endif

### src/pfa_pkg.sv
// Package: constants, types and helpers of the page frame allocator.
package pfa_pkg;

  localparam int NUM_FRAMES = 64;
  localparam int OWNER_BITS = 8;

  localparam int FRAME_AW  = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CNT_W     = $clog2(NUM_FRAMES + 1);
  localparam int ENT_W     = OWNER_BITS + 1;
  localparam int CMP_W     = 11;
  localparam int FIELD_W   = 7;
  localparam int FIELD_MAX = 127;

  localparam logic KIND_ALLOC   = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // Free count as reported on the 7-bit result field, saturating.
  function automatic logic [FIELD_W-1:0] sat_free(input logic [CNT_W-1:0] cnt);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(cnt);
    if (ext > CMP_W'(FIELD_MAX)) begin
      sat_free = FIELD_W'(FIELD_MAX);
    end else begin
      sat_free = ext[FIELD_W-1:0];
    end
  endfunction

endpackage

### src/pfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/page_frame_allocator.sv
// Top level: first-fit page frame allocator with a RAM-held frame table.
//
// Usage:
//   Command channel: a request transfers at a rising clk edge where start is
//   high and busy is low. in_kind selects allocate (0) or release (1),
//   in_owner_id names the owner, in_pages_wanted the frames wanted on allocate.
//   Result channel: out_valid strobes for exactly one cycle with out_granted and
//   out_free_count (free count after the request, saturated at 127). The
//   receiver cannot stall; every result must be taken in its strobe cycle.
// Timing:
//   A refused or zero-page allocate: out_valid is high in the cycle after the
//   transfer and busy stays low, so the next request may transfer at once.
//   Any other request walks the frame table through the RAM read port, one
//   frame per cycle, with registered read data: busy stays high through the
//   walk, then out_valid strobes and the next request may transfer at the
//   edge ending the strobe.
// Reset:
//   rst_n low clears the frame valid bits (all frames free), the free count to
//   NUM_FRAMES and the sequencer to idle. The RAM itself is never cleared: an
//   entry without its valid bit reads as a free frame.
module page_frame_allocator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_kind,
  input  logic [7:0] in_owner_id,
  input  logic [6:0] in_pages_wanted,
  output logic       out_valid,
  output logic       out_granted,
  output logic [6:0] out_free_count
);

  import pfa_pkg::*;

  // Sequencer state
  state_t                state_r, state_nxt;
  logic                  kind_r, kind_nxt;
  logic [OWNER_BITS-1:0] who_r, who_nxt;
  logic [FIELD_W-1:0]    left_r, left_nxt;
  logic [CNT_W-1:0]      free_r, free_nxt;
  logic [CNT_W-1:0]      rd_cnt_r, rd_cnt_nxt;

  // Read stage: entry whose data comes out of the RAM this cycle
  logic                  s1_v_r, s1_v_nxt;
  logic [FRAME_AW-1:0]   s1_addr_r, s1_addr_nxt;

  // Per-frame written marks; an unmarked frame reads as free
  logic [NUM_FRAMES-1:0] valid_r, valid_nxt;

  // Result register
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_granted_r, out_granted_nxt;
  logic [FIELD_W-1:0]    out_free_r, out_free_nxt;

  // RAM port signals
  logic                  ram_we;
  logic [FRAME_AW-1:0]   ram_waddr;
  logic [ENT_W-1:0]      ram_wdata;
  logic                  ram_re;
  logic [FRAME_AW-1:0]   ram_raddr;
  logic [ENT_W-1:0]      ram_rdata;

  logic                  accept;
  logic                  ent_used;
  logic [OWNER_BITS-1:0] ent_owner;
  logic                  last_entry;
  logic [CMP_W-1:0]      want_ext;
  logic [CMP_W-1:0]      free_ext;

  // Frame table: {used, owner} per frame
  pfa_ram #(
    .WIDTH(ENT_W),
    .DEPTH(NUM_FRAMES)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign ent_used   = valid_r[s1_addr_r] & ram_rdata[ENT_W-1];
  assign ent_owner  = ram_rdata[OWNER_BITS-1:0];
  assign last_entry = (s1_addr_r == FRAME_AW'(NUM_FRAMES - 1));
  assign want_ext   = CMP_W'(in_pages_wanted);
  assign free_ext   = CMP_W'(free_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      free_r      <= CNT_W'(NUM_FRAMES);
      valid_r     <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_r      <= free_nxt;
      valid_r     <= valid_nxt;
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    kind_r        <= kind_nxt;
    who_r         <= who_nxt;
    left_r        <= left_nxt;
    rd_cnt_r      <= rd_cnt_nxt;
    s1_addr_r     <= s1_addr_nxt;
    out_granted_r <= out_granted_nxt;
    out_free_r    <= out_free_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    kind_nxt        = kind_r;
    who_nxt         = who_r;
    left_nxt        = left_r;
    free_nxt        = free_r;
    rd_cnt_nxt      = rd_cnt_r;
    s1_v_nxt        = 1'b0;
    s1_addr_nxt     = s1_addr_r;
    valid_nxt       = valid_r;
    out_valid_nxt   = 1'b0;
    out_granted_nxt = out_granted_r;
    out_free_nxt    = out_free_r;
    ram_we          = 1'b0;
    ram_waddr       = s1_addr_r;
    ram_wdata       = {1'b0, who_r};
    ram_re          = 1'b0;
    ram_raddr       = rd_cnt_r[FRAME_AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          kind_nxt   = in_kind;
          who_nxt    = OWNER_BITS'(in_owner_id);
          left_nxt   = in_pages_wanted;
          rd_cnt_nxt = '0;
          if (in_kind == KIND_ALLOC && want_ext > free_ext) begin
            // refused: nothing changes
            out_valid_nxt   = 1'b1;
            out_granted_nxt = 1'b0;
            out_free_nxt    = sat_free(free_r);
          end else if (in_kind == KIND_ALLOC && in_pages_wanted == '0) begin
            // zero-page allocate claims nothing
            out_valid_nxt   = 1'b1;
            out_granted_nxt = 1'b1;
            out_free_nxt    = sat_free(free_r);
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // issue side: one table read per cycle
        if (rd_cnt_r != CNT_W'(NUM_FRAMES)) begin
          ram_re      = 1'b1;
          s1_v_nxt    = 1'b1;
          s1_addr_nxt = rd_cnt_r[FRAME_AW-1:0];
          rd_cnt_nxt  = rd_cnt_r + CNT_W'(1);
        end
        // modify/write-back side; the write address never matches the read
        if (s1_v_r) begin
          if (kind_r == KIND_RELEASE) begin
            if (ent_used && ent_owner == who_r) begin
              ram_we    = 1'b1;
              ram_wdata = {1'b0, who_r};
              valid_nxt[s1_addr_r] = 1'b1;
              free_nxt  = free_r + CNT_W'(1);
            end
          end else begin
            if (!ent_used && left_r != '0) begin
              ram_we    = 1'b1;
              ram_wdata = {1'b1, who_r};
              valid_nxt[s1_addr_r] = 1'b1;
              left_nxt  = left_r - FIELD_W'(1);
              free_nxt  = free_r - CNT_W'(1);
            end
          end
          if (last_entry) begin
            state_nxt       = ST_IDLE;
            out_valid_nxt   = 1'b1;
            out_granted_nxt = 1'b1;
            out_free_nxt    = sat_free(free_nxt);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_granted    = out_granted_r;
  assign out_free_count = out_free_r;

`include "page_frame_allocator_defines.svh"

  `PFA_ASSERT_IMPL(a_free_bound, 1'b1, free_r <= CNT_W'(NUM_FRAMES))
  `PFA_ASSERT_IMPL(a_result_idle, out_valid_r, state_r == ST_IDLE)
  `PFA_ASSERT_IMPL(a_alloc_filled,
    state_r == ST_SCAN && s1_v_r && last_entry && kind_r == KIND_ALLOC, left_nxt == '0)
  `PFA_ASSERT_NEXT(a_scan_reports, state_r == ST_SCAN && state_nxt == ST_IDLE, out_valid_r && out_granted_r)

endmodule
